// ===== rtl/hmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hmc_pkg;

	localparam int FRAC_BITS_DEF       = 16;
	localparam int TRIG_ITERATIONS_DEF = 16;

	localparam logic [2:0] KIND_IDENT = 3'd0;
	localparam logic [2:0] KIND_TRANS = 3'd1;
	localparam logic [2:0] KIND_SCALE = 3'd2;
	localparam logic [2:0] KIND_ROT   = 3'd3;
	localparam logic [2:0] KIND_PERSP = 3'd4;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [31:0]        PI_Q30      = 32'd3373259426;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_MULPI,
		ST_DIVZ,
		ST_CORD,
		ST_CONV,
		ST_MUL,
		ST_FLUSH,
		ST_OUT
	} state_t;

	// atan(2^-i) in Q2.30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] v;
		begin
			unique case (i)
				5'd0:  v = 34'sd843314857;
				5'd1:  v = 34'sd497837829;
				5'd2:  v = 34'sd263043837;
				5'd3:  v = 34'sd133525159;
				5'd4:  v = 34'sd67021687;
				5'd5:  v = 34'sd33543516;
				5'd6:  v = 34'sd16775851;
				5'd7:  v = 34'sd8388437;
				5'd8:  v = 34'sd4194283;
				5'd9:  v = 34'sd2097141;
				5'd10: v = 34'sd1048575;
				5'd11: v = 34'sd524288;
				5'd12: v = 34'sd262144;
				5'd13: v = 34'sd131072;
				5'd14: v = 34'sd65536;
				5'd15: v = 34'sd32768;
				5'd16: v = 34'sd16384;
				5'd17: v = 34'sd8192;
				5'd18: v = 34'sd4096;
				5'd19: v = 34'sd2048;
				5'd20: v = 34'sd1024;
				5'd21: v = 34'sd512;
				5'd22: v = 34'sd256;
				5'd23: v = 34'sd128;
				default: v = 34'sd0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hmc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface hmc_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic signed [31:0] arg_a;
	logic signed [31:0] arg_b;
	modport source (output valid, kind, arg_a, arg_b, input ready);
	modport sink (input valid, kind, arg_a, arg_b, output ready);
endinterface

interface hmc_mat_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/homogeneous_matrix_composer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Holds a 3x3 transform in signed fixed point and post-multiplies it by a
// translate, scale, rotate or perspective matrix per command beat; identity
// reloads the unit matrix, unknown kinds leave it alone. Every command yields
// one beat with all nine entries. Translate, scale and perspective go through
// the shared 32x9-bit digit multiplier that walks 5 byte digits of each of 27
// products; rotate first runs the bit-serial angle reduction, the bit-serial
// degree to radian conversion and the CORDIC loop. A new command is taken
// while a finished result still waits on the output.
module homogeneous_matrix_composer #(
	parameter int FRAC_BITS       = hmc_pkg::FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS = hmc_pkg::TRIG_ITERATIONS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	hmc_cmd_if.sink   cmd,
	hmc_mat_if.source mat
);

	localparam logic [63:0] FULL    = 64'd360 << FRAC_BITS;
	localparam logic [63:0] QUARTER = 64'd90 << FRAC_BITS;
	localparam logic [63:0] HALF    = 64'd180 << FRAC_BITS;
	localparam logic [63:0] HHALF   = HALF >> 1;
	localparam logic [63:0] KOFF    = (64'd2147483648 + FULL - 64'd1) / FULL;
	localparam logic [63:0] OFF     = KOFF * FULL;
	localparam int UW  = $clog2(64'd2147483648 + OFF);
	localparam int RW  = $clog2(QUARTER) + 1;
	localparam int HW  = $clog2(HALF) + 1;
	localparam int SH  = 30 - FRAC_BITS;
	localparam int DIG = 5;
	localparam int AW  = 68;
	localparam logic [31:0]        ONE   = 32'(64'd1 << FRAC_BITS);
	localparam logic signed [39:0] ONE40 = 40'(64'd1 << FRAC_BITS);
	localparam logic signed [33:0] CRND  = 34'(64'd1 << (SH - 1));
	localparam logic signed [AW-1:0] PRND = AW'(64'd1 << (FRAC_BITS - 1));

	hmc_pkg::state_t state_q, state_d;

	logic [6:0]          cnt_q;
	logic [2:0]          kind_q;
	logic signed [31:0]  a_q, b_q;
	logic [UW-1:0]       u_q;
	logic [RW-1:0]       rem_q;
	logic [1:0]          qq_q;
	logic [63:0]         n_q;
	logic [HW-1:0]       dr_q;
	logic [31:0]         zq_q;
	logic signed [33:0]  x_q, y_q, z_q;
	logic signed [33:0]  cs_q, sn_q;
	logic signed [31:0]  m_q [9];
	logic signed [31:0]  res_q [9];
	logic signed [31:0]  mo_q [9];
	logic                ov_q;
	logic [1:0]          r_q, c_q, k_q;
	logic [2:0]          d_q;
	logic signed [40:0]  prod_s1;
	logic                v_s1, first_s1, last_s1;
	logic [3:0]          idx_s1;
	logic signed [AW-1:0] acc_q, fin_s2;
	logic                v_s2;
	logic [3:0]          idx_s2;

	logic cmd_rdy, issue, load_out, commit, out_free, issue_last, drained;

	assign out_free   = !ov_q || mat.ready;
	assign issue_last = (r_q == 2'd2) && (c_q == 2'd2) && (d_q == 3'd0) && (k_q == 2'd2);
	assign drained    = !v_s1 && !v_s2;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hmc_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					priority if (cmd.kind == hmc_pkg::KIND_ROT)
						state_d = hmc_pkg::ST_DIV;
					else if (cmd.kind == hmc_pkg::KIND_TRANS || cmd.kind == hmc_pkg::KIND_SCALE
						|| cmd.kind == hmc_pkg::KIND_PERSP)
						state_d = hmc_pkg::ST_MUL;
					else
						state_d = hmc_pkg::ST_OUT;
				end
			end
			hmc_pkg::ST_DIV:   if (cnt_q == 7'(UW - 1)) state_d = hmc_pkg::ST_MULPI;
			hmc_pkg::ST_MULPI: if (cnt_q == 7'(RW - 1)) state_d = hmc_pkg::ST_DIVZ;
			hmc_pkg::ST_DIVZ:  if (cnt_q == 7'd63) state_d = hmc_pkg::ST_CORD;
			hmc_pkg::ST_CORD:  if (cnt_q == 7'(TRIG_ITERATIONS - 1)) state_d = hmc_pkg::ST_CONV;
			hmc_pkg::ST_CONV:  state_d = hmc_pkg::ST_MUL;
			hmc_pkg::ST_MUL:   if (issue_last) state_d = hmc_pkg::ST_FLUSH;
			hmc_pkg::ST_FLUSH: if (drained) state_d = hmc_pkg::ST_OUT;
			hmc_pkg::ST_OUT:   if (out_free) state_d = hmc_pkg::ST_IDLE;
			default:           state_d = hmc_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_rdy  = (state_q == hmc_pkg::ST_IDLE);
		issue    = (state_q == hmc_pkg::ST_MUL);
		commit   = (state_q == hmc_pkg::ST_FLUSH) && drained;
		load_out = (state_q == hmc_pkg::ST_OUT) && out_free;
	end

	assign cmd.ready = cmd_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmc_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 7'd0 : cnt_q + 7'd1;
		end
	end

	// angle path: reduce, convert to radians, CORDIC
	logic [UW-1:0]       u_init;
	logic [RW-1:0]       dv_tr;
	logic                dv_ge;
	logic [63:0]         pi_next;
	logic [HW-1:0]       dz_tr;
	logic                dz_ge;
	logic [4:0]          ci;
	logic signed [33:0]  cdx, cdy, cat, xs, ys;

	always_comb begin
		u_init  = {{(UW - 32){cmd.arg_a[31]}}, cmd.arg_a} + UW'(OFF);
		dv_tr   = {rem_q[RW-2:0], u_q[UW-1]};
		dv_ge   = (dv_tr >= RW'(QUARTER));
		pi_next = {n_q[62:0], 1'b0} + (rem_q[RW-1] ? {32'd0, hmc_pkg::PI_Q30} : 64'd0);
		dz_tr   = {dr_q[HW-2:0], n_q[63]};
		dz_ge   = (dz_tr >= HW'(HALF));
		ci      = cnt_q[4:0];
		cdx     = y_q >>> ci;
		cdy     = x_q >>> ci;
		cat     = hmc_pkg::atan_q30(ci);
		xs      = (x_q + CRND) >>> SH;
		ys      = (y_q + CRND) >>> SH;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			hmc_pkg::ST_IDLE: begin
				kind_q <= cmd.kind;
				a_q    <= cmd.arg_a;
				b_q    <= cmd.arg_b;
				u_q    <= u_init;
				rem_q  <= '0;
				qq_q   <= '0;
			end
			hmc_pkg::ST_DIV: begin
				// one quotient bit a cycle
				u_q   <= {u_q[UW-2:0], 1'b0};
				rem_q <= dv_ge ? dv_tr - RW'(QUARTER) : dv_tr;
				qq_q  <= {qq_q[0], dv_ge};
				n_q   <= '0;
			end
			hmc_pkg::ST_MULPI: begin
				rem_q <= {rem_q[RW-2:0], 1'b0};
				n_q   <= (cnt_q == 7'(RW - 1)) ? pi_next + HHALF : pi_next;
				dr_q  <= '0;
			end
			hmc_pkg::ST_DIVZ: begin
				n_q  <= {n_q[62:0], 1'b0};
				dr_q <= dz_ge ? dz_tr - HW'(HALF) : dz_tr;
				zq_q <= {zq_q[30:0], dz_ge};
				x_q  <= hmc_pkg::CORDIC_GAIN;
				y_q  <= '0;
				z_q  <= {2'b00, zq_q[30:0], dz_ge};
			end
			hmc_pkg::ST_CORD: begin
				if (!z_q[33]) begin
					x_q <= x_q - cdx;
					y_q <= y_q + cdy;
					z_q <= z_q - cat;
				end else begin
					x_q <= x_q + cdx;
					y_q <= y_q - cdy;
					z_q <= z_q + cat;
				end
			end
			hmc_pkg::ST_CONV: begin
				// map the quadrant onto cos and sin
				unique case (qq_q)
					2'd0: begin cs_q <= xs;  sn_q <= ys;  end
					2'd1: begin cs_q <= -ys; sn_q <= xs;  end
					2'd2: begin cs_q <= -xs; sn_q <= -ys; end
					default: begin cs_q <= ys; sn_q <= -xs; end
				endcase
			end
			default: ;
		endcase
	end

	// product walk: per entry, byte digits of E from the top, three entries of a row of M each
	logic [3:0]          ma_idx, e_idx;
	logic signed [39:0]  ev;
	logic [7:0]          dg;
	logic signed [40:0]  a_ext, dig_ext, prod;
	logic signed [AW-1:0] acc_sh, acc_new, rnd;
	logic signed [31:0]  ent;

	always_comb begin
		ma_idx = {2'b00, r_q} * 4'd3 + {2'b00, k_q};
		e_idx  = {2'b00, k_q} * 4'd3 + {2'b00, c_q};
		ev = (e_idx == 4'd0 || e_idx == 4'd4 || e_idx == 4'd8) ? ONE40 : 40'sd0;
		unique case (kind_q)
			hmc_pkg::KIND_TRANS: begin
				if (e_idx == 4'd2) ev = 40'(a_q);
				if (e_idx == 4'd5) ev = 40'(b_q);
			end
			hmc_pkg::KIND_SCALE: begin
				if (e_idx == 4'd0) ev = 40'(a_q);
				if (e_idx == 4'd4) ev = 40'(b_q);
			end
			hmc_pkg::KIND_ROT: begin
				if (e_idx == 4'd0 || e_idx == 4'd4) ev = 40'(cs_q);
				if (e_idx == 4'd1) ev = -40'(sn_q);
				if (e_idx == 4'd3) ev = 40'(sn_q);
			end
			hmc_pkg::KIND_PERSP: begin
				if (e_idx == 4'd6) ev = 40'(a_q);
				if (e_idx == 4'd7) ev = 40'(b_q);
			end
			default: ;
		endcase
		dg      = ev[d_q*8 +: 8];
		a_ext   = 41'(m_q[ma_idx]);
		dig_ext = (d_q == 3'(DIG - 1)) ? 41'($signed(dg)) : {33'd0, dg};
		prod    = a_ext * dig_ext;
		acc_sh  = first_s1 ? (acc_q <<< 8) : acc_q;
		acc_new = acc_sh + AW'(prod_s1);
		rnd     = (fin_s2 + PRND) >>> FRAC_BITS;
		if (rnd > AW'(64'sd2147483647))
			ent = 32'sh7fffffff;
		else if (rnd < -AW'(64'sd2147483648))
			ent = 32'sh80000000;
		else
			ent = rnd[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			c_q   <= '0;
			k_q   <= '0;
			d_q   <= 3'(DIG - 1);
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && last_s1;
			// advance the digit counters
			if (issue) begin
				if (k_q == 2'd2) begin
					k_q <= '0;
					if (d_q == 3'd0) begin
						d_q <= 3'(DIG - 1);
						if (c_q == 2'd2) begin
							c_q <= '0;
							r_q <= (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end else begin
						d_q <= d_q - 3'd1;
					end
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			if (v_s1)
				acc_q <= last_s1 ? '0 : acc_new;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= prod;
		first_s1 <= (k_q == 2'd0);
		last_s1  <= (k_q == 2'd2) && (d_q == 3'd0);
		idx_s1   <= {2'b00, r_q} * 4'd3 + {2'b00, c_q};
		fin_s2   <= acc_new;
		idx_s2   <= idx_s1;
		if (v_s2)
			res_q[idx_s2] <= ent;
	end

	// held matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				m_q[i] <= (i % 4 == 0) ? ONE : 32'sd0;
		end else if (cmd_rdy && cmd.valid && cmd.kind == hmc_pkg::KIND_IDENT) begin
			for (int i = 0; i < 9; i++)
				m_q[i] <= (i % 4 == 0) ? ONE : 32'sd0;
		end else if (commit) begin
			for (int i = 0; i < 9; i++)
				m_q[i] <= res_q[i];
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (load_out)
			ov_q <= 1'b1;
		else if (mat.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			for (int i = 0; i < 9; i++)
				mo_q[i] <= m_q[i];
	end

	assign mat.valid = ov_q;
	assign mat.m00 = mo_q[0];
	assign mat.m01 = mo_q[1];
	assign mat.m02 = mo_q[2];
	assign mat.m10 = mo_q[3];
	assign mat.m11 = mo_q[4];
	assign mat.m12 = mo_q[5];
	assign mat.m20 = mo_q[6];
	assign mat.m21 = mo_q[7];
	assign mat.m22 = mo_q[8];

`ifndef SYNTHESIS
	a_rnd_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == hmc_pkg::ST_MUL || state_q == hmc_pkg::ST_FLUSH))
		else $error("rounding stage active outside the product walk");
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd_rdy && cmd.kind == hmc_pkg::KIND_IDENT)
		|=> (m_q[0] == ONE && m_q[1] == 32'sd0 && m_q[8] == ONE))
		else $error("identity not loaded");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> mat.valid)
		else $error("result not presented");
	a_cord: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hmc_pkg::ST_CORD) |-> (cnt_q < 7'(TRIG_ITERATIONS)))
		else $error("CORDIC step count overrun");
`endif

endmodule
`default_nettype wire

// ===== bench/hmc_matrix_checker.sv =====
`timescale 1ns / 1ps
module hmc_matrix_checker (
	input  logic clk,
	input  logic arst_n,
	hmc_cmd_if   cmd,
	hmc_mat_if   mat,
	output int   mismatches,
	output int   matrices_pending,
	output int   matrices_checked,
	output int   rotates_seen
);

	localparam int FRAC = hmc_pkg::FRAC_BITS_DEF;
	localparam int ITERS = hmc_pkg::TRIG_ITERATIONS_DEF;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint unsigned PI_FIX = 64'd3373259426;
	localparam longint ARCTAN_Q30 [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097141, 1048575, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	typedef struct {
		logic signed [31:0] entry [9];
	} matrix_t;

	longint  held [9];
	matrix_t expected_matrices [$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic void load_unit();
		for (int k = 0; k < 9; k++)
			held[k] = (k % 4 == 0) ? ONE : 0;
	endfunction

	// held := held * e, each sum rounded half up and clamped
	function automatic void compose(longint e [9]);
		longint res [9];
		longint hi, lo, p;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				hi = 0;
				lo = 0;
				for (int k = 0; k < 3; k++) begin
					p = held[r*3+k] * e[k*3+c];
					hi += p >>> FRAC;
					lo += p & (ONE - 1);
				end
				hi += (lo + (ONE >>> 1)) >>> FRAC;
				res[r*3+c] = clamp32(hi);
			end
		end
		held = res;
	endfunction

	// cosine and sine of an angle in fixed-point degrees
	function automatic void trig(longint deg, output longint cs, output longint sn);
		longint full, quarter, r, q, rem, x, y, z, dx, dy, c, s;
		longint unsigned half_turn;
		full = longint'(360) << FRAC;
		quarter = longint'(90) << FRAC;
		half_turn = longint'(180) << FRAC;
		r = deg % full;
		if (r < 0)
			r += full;
		q = r / quarter;
		rem = r - q * quarter;
		z = longint'((longint'(unsigned'(rem)) * PI_FIX + half_turn / 2) / half_turn);
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < ITERS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ARCTAN_Q30[i];
			end else begin
				x += dx; y -= dy; z += ARCTAN_Q30[i];
			end
		end
		c = (x + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
		s = (y + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
		case (q)
			0: begin cs = c; sn = s; end
			1: begin cs = -s; sn = c; end
			2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic matrix_t next_matrix(logic [2:0] kind, longint a, longint b);
		longint e [9];
		longint cs, sn;
		matrix_t m;
		e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		case (kind)
			hmc_pkg::KIND_IDENT: load_unit();
			hmc_pkg::KIND_TRANS: begin e[2] = a; e[5] = b; compose(e); end
			hmc_pkg::KIND_SCALE: begin e[0] = a; e[4] = b; compose(e); end
			hmc_pkg::KIND_ROT: begin
				trig(a, cs, sn);
				e[0] = cs; e[1] = -sn; e[3] = sn; e[4] = cs;
				compose(e);
			end
			hmc_pkg::KIND_PERSP: begin e[6] = a; e[7] = b; compose(e); end
			default: ;
		endcase
		for (int k = 0; k < 9; k++)
			m.entry[k] = held[k][31:0];
		return m;
	endfunction

	// predict on each command beat, compare on each matrix beat
	always @(posedge clk or negedge arst_n) begin
		matrix_t want;
		logic signed [31:0] got [9];
		if (!arst_n) begin
			load_unit();
			expected_matrices.delete();
			mismatches <= 0;
			matrices_pending <= 0;
			matrices_checked <= 0;
			rotates_seen <= 0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				expected_matrices.push_back(next_matrix(cmd.kind, longint'(cmd.arg_a),
					longint'(cmd.arg_b)));
				if (cmd.kind == hmc_pkg::KIND_ROT)
					rotates_seen <= rotates_seen + 1;
			end
			if (mat.valid && mat.ready) begin
				got = '{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
					mat.m20, mat.m21, mat.m22};
				matrices_checked <= matrices_checked + 1;
				if (expected_matrices.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: matrix beat with nothing expected", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_matrices.pop_front();
					if (got != want.entry) begin
						if (mismatches < 10)
							for (int k = 0; k < 9; k++)
								if (got[k] != want.entry[k])
									$display("%0t: m%0d%0d expected %0d got %0d", $realtime,
										k / 3, k % 3, want.entry[k], got[k]);
						mismatches <= mismatches + 1;
					end
				end
			end
			matrices_pending <= expected_matrices.size();
		end
	end
endmodule

// ===== bench/tb_homogeneous_matrix_composer.sv =====
`timescale 1ns / 1ps
module tb_homogeneous_matrix_composer;

	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;
	localparam int RANDOM_OPS = 1150;
	localparam int QUIET_TAIL = 150;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	int   stall_left = 0;
	int   mismatches, matrices_pending, matrices_checked, rotates_seen;

	hmc_cmd_if cmd_if();
	hmc_mat_if mat_if();

	homogeneous_matrix_composer dut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_if), .mat(mat_if)
	);

	hmc_matrix_checker chk (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_if), .mat(mat_if),
		.mismatches(mismatches), .matrices_pending(matrices_pending),
		.matrices_checked(matrices_checked), .rotates_seen(rotates_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stall the matrix side in bursts, none in the tail
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			mat_if.ready <= arst_n;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			mat_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			mat_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			mat_if.ready <= 1'b1;
		end
	end

	// one command beat, optionally followed by an idle burst
	task automatic issue(logic [2:0] kind, logic signed [31:0] a, logic signed [31:0] b);
		int gap;
		cmd_if.valid <= 1'b1;
		cmd_if.kind <= kind;
		cmd_if.arg_a <= a;
		cmd_if.arg_b <= b;
		do @(negedge clk); while (!cmd_if.ready);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_arg(logic [2:0] kind);
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 15)
			return $urandom();
		if (kind == hmc_pkg::KIND_ROT)
			return (mode < 60) ? $urandom_range(0, 360 << 16)
				: $signed($urandom_range(0, 1440 << 16)) - (720 <<< 16);
		if (kind == hmc_pkg::KIND_SCALE)
			return $urandom_range(Q_ONE / 2, Q_ONE * 2) * ($urandom_range(0, 3) == 0 ? -1 : 1);
		if (kind == hmc_pkg::KIND_PERSP)
			return $signed($urandom_range(0, 2048)) - 1024;
		return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
	endfunction

	initial begin
		int r;
		logic [2:0] kind;
		cmd_if.valid = 1'b0;
		cmd_if.kind = hmc_pkg::KIND_IDENT;
		cmd_if.arg_a = '0;
		cmd_if.arg_b = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, field extremes, quadrants, saturation, spare kinds
		issue(hmc_pkg::KIND_IDENT, MAX32, MIN32);
		issue(hmc_pkg::KIND_TRANS, MAX32, MIN32);
		issue(hmc_pkg::KIND_TRANS, MIN32, MAX32);
		issue(hmc_pkg::KIND_IDENT, '0, '0);
		issue(hmc_pkg::KIND_SCALE, MAX32, MIN32);
		issue(hmc_pkg::KIND_SCALE, MAX32, MAX32);
		issue(hmc_pkg::KIND_IDENT, '0, '0);
		issue(hmc_pkg::KIND_ROT, 0, '0);
		issue(hmc_pkg::KIND_ROT, 90 <<< 16, '0);
		issue(hmc_pkg::KIND_ROT, 180 <<< 16, '0);
		issue(hmc_pkg::KIND_ROT, 270 <<< 16, '0);
		issue(hmc_pkg::KIND_ROT, -(90 <<< 16), '0);
		issue(hmc_pkg::KIND_ROT, 360 <<< 16, '0);
		issue(hmc_pkg::KIND_ROT, MAX32, MIN32);
		issue(hmc_pkg::KIND_ROT, MIN32, MAX32);
		issue(hmc_pkg::KIND_PERSP, Q_ONE / 4, -(Q_ONE / 8));
		issue(hmc_pkg::KIND_PERSP, MAX32, MIN32);
		issue(KIND_SPARE_5, MAX32, MAX32);
		issue(KIND_SPARE_6, '0, '0);
		issue(KIND_SPARE_7, MIN32, MIN32);
		issue(hmc_pkg::KIND_IDENT, '0, '0);
		issue(hmc_pkg::KIND_SCALE, '0, '0);

		// random chains, reset to identity now and then
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS - QUIET_TAIL)
				quiet <= 1'b1;
			r = $urandom_range(0, 99);
			kind = (r < 8) ? hmc_pkg::KIND_IDENT : (r < 30) ? hmc_pkg::KIND_TRANS
				: (r < 50) ? hmc_pkg::KIND_SCALE
				: (r < 75) ? hmc_pkg::KIND_ROT : (r < 95) ? hmc_pkg::KIND_PERSP
				: 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));
			issue(kind, pick_arg(kind), pick_arg(kind));
		end
		cmd_if.valid <= 1'b0;
		@(posedge clk);

		while (matrices_pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Checked %0d matrices (%0d rotations) over all kinds, with idle and stall",
			matrices_checked, rotates_seen);
		$display("bursts on both sides; %0d mismatching matrices.", mismatches);
		if (mismatches == 0)
			$display("homogeneous_matrix_composer regression: pass");
		else
			$display("homogeneous_matrix_composer regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("homogeneous_matrix_composer regression: fail");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/hmc_pkg.sv
rtl/hmc_if.sv
rtl/homogeneous_matrix_composer.sv
bench/hmc_matrix_checker.sv
bench/tb_homogeneous_matrix_composer.sv
